FILE: rtl/cwp_pkg.sv
// Shared types, constants and geometry functions for the clock wipe polygon block.
`timescale 1ns / 1ps
package cwp_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int EIGHTH    = ONE / 8;
  localparam int HALF      = ONE / 2;

  localparam int IN_ANG_W  = 14;
  localparam int FILL_W    = 13;
  localparam int REL_W     = 13;
  localparam int SCR_W     = 16;
  localparam int TEX_W     = 13;
  localparam int ANG_W     = 18;
  localparam int SWEEP_W   = IN_ANG_W + 1 + FILL_W + 1;
  localparam int MAX_CORNERS = 8;
  localparam int CNT_W     = 4;

  localparam int PS_W      = SCR_W + 1 + REL_W + 1;
  localparam int PT_W      = TEX_W + 1 + REL_W + 1;

  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 88;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_LEFT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_TOP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_RIGHT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_BOTTOM  = 3'd7;

  typedef logic signed [ANG_W-1:0] angle_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SWEEP,
    FR_BEGIN,
    FR_CORNER
  } fr_state_t;

  typedef struct packed {
    angle_t angle;
    logic   center;
    logic   last;
  } vtx_cmd_t;

  typedef struct packed {
    logic [REL_W-1:0] x;
    logic [REL_W-1:0] y;
  } rel_pt_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] rect_left;
    logic signed [SCR_W-1:0] rect_top;
    logic signed [SCR_W-1:0] rect_right;
    logic signed [SCR_W-1:0] rect_bottom;
    logic [TEX_W-1:0]        tex_left;
    logic [TEX_W-1:0]        tex_top;
    logic [TEX_W-1:0]        tex_right;
    logic [TEX_W-1:0]        tex_bottom;
  } cwp_cfg_t;

  function automatic angle_t next_corner(angle_t a);
    angle_t c;
    angle_t r;
    r = a + angle_t'(2 * EIGHTH);
    for (int k = MAX_CORNERS - 1; k >= 0; k--) begin
      c = angle_t'((2 * k - 7) * EIGHTH);
      if (a < c) r = c;
    end
    return r;
  endfunction

  function automatic angle_t prev_corner(angle_t a);
    angle_t c;
    angle_t r;
    r = a - angle_t'(2 * EIGHTH);
    for (int k = 0; k < MAX_CORNERS; k++) begin
      c = angle_t'((2 * k - 7) * EIGHTH);
      if (a > c) r = c;
    end
    return r;
  endfunction

  function automatic rel_pt_t perimeter(angle_t a);
    logic signed [ANG_W+1:0] a4;
    logic signed [ANG_W+1:0] x;
    logic signed [ANG_W+1:0] y;
    rel_pt_t p;
    a4 = (ANG_W+2)'(a) <<< 2;
    x  = (ANG_W+2)'(HALF);
    y  = '0;
    if (a < -ONE) begin
      x = (ANG_W+2)'(HALF);
      y = '0;
    end else if (a <= -7 * EIGHTH) begin
      x = a4 + (ANG_W+2)'(9 * HALF);
      y = '0;
    end else if (a <= -5 * EIGHTH) begin
      x = (ANG_W+2)'(ONE);
      y = a4 + (ANG_W+2)'(7 * HALF);
    end else if (a <= -3 * EIGHTH) begin
      x = (ANG_W+2)'(-3 * HALF) - a4;
      y = (ANG_W+2)'(ONE);
    end else if (a <= -EIGHTH) begin
      x = '0;
      y = (ANG_W+2)'(-HALF) - a4;
    end else if (a <= EIGHTH) begin
      x = (ANG_W+2)'(HALF) + a4;
      y = '0;
    end else if (a <= 3 * EIGHTH) begin
      x = (ANG_W+2)'(ONE);
      y = a4 - (ANG_W+2)'(HALF);
    end else if (a <= 5 * EIGHTH) begin
      x = (ANG_W+2)'(5 * HALF) - a4;
      y = (ANG_W+2)'(ONE);
    end else if (a <= 7 * EIGHTH) begin
      x = '0;
      y = (ANG_W+2)'(7 * HALF) - a4;
    end else if (a <= ONE) begin
      x = a4 - (ANG_W+2)'(7 * HALF);
      y = '0;
    end
    p.x = x[REL_W-1:0];
    p.y = y[REL_W-1:0];
    return p;
  endfunction

endpackage

FILE: rtl/clock_wipe_polygon.sv
// Top level of the square clock wipe triangle fan generator.
//
//   port group   dir   beat contents (low bit first)
//   s_*          in    begin_angle[13:0], end_angle[27:14], fill_factor[40:28]
//   m_*          out   rel_x, rel_y, screen_x, screen_y, tex_u, tex_v; tlast = last_vertex
//   cfg_*        in    register write, index 0..7, data 16 bits
//
// A request passes the corner walker's sweep, begin and corner states and yields at most 8 corners;
// the walker takes no new request until it is back in idle, and it is the rate limit.
// Vertices leave the three-stage output pipeline one per cycle while the output is not stalled.
// A four-entry command queue lets the walker run ahead while the output is stalled.
// Synchronous reset zeroes the config, idles the walker and empties the queue and pipeline.
`timescale 1ns / 1ps
module clock_wipe_polygon (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cwp_pkg::S_DATA_W-1:0]  s_tdata,   // begin_angle, end_angle, fill_factor
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cwp_pkg::M_DATA_W-1:0]  m_tdata,   // rel_x, rel_y, screen_x, screen_y, tex_u, tex_v
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [cwp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [cwp_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  cwp_pkg::cwp_cfg_t cfg;
  logic              push;
  cwp_pkg::vtx_cmd_t push_data;
  logic              full;
  logic              pop;
  cwp_pkg::vtx_cmd_t pop_data;
  logic              empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        cwp_pkg::REG_RECT_LEFT:   cfg.rect_left   <= cfg_wdata;
        cwp_pkg::REG_RECT_TOP:    cfg.rect_top    <= cfg_wdata;
        cwp_pkg::REG_RECT_RIGHT:  cfg.rect_right  <= cfg_wdata;
        cwp_pkg::REG_RECT_BOTTOM: cfg.rect_bottom <= cfg_wdata;
        cwp_pkg::REG_TEX_LEFT:    cfg.tex_left    <= cfg_wdata[cwp_pkg::TEX_W-1:0];
        cwp_pkg::REG_TEX_TOP:     cfg.tex_top     <= cfg_wdata[cwp_pkg::TEX_W-1:0];
        cwp_pkg::REG_TEX_RIGHT:   cfg.tex_right   <= cfg_wdata[cwp_pkg::TEX_W-1:0];
        cwp_pkg::REG_TEX_BOTTOM:  cfg.tex_bottom  <= cfg_wdata[cwp_pkg::TEX_W-1:0];
        default:                  cfg <= cfg;
      endcase
    end
  end

  cwp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  cwp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cwp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/cwp_front.sv
// Front end: accepts requests, computes the swept end angle and walks the corners.
`timescale 1ns / 1ps
module cwp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cwp_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          push,
  output cwp_pkg::vtx_cmd_t             push_data,
  input  logic                          full
);

  cwp_pkg::fr_state_t state;
  cwp_pkg::fr_state_t state_next;

  cwp_pkg::angle_t b;
  cwp_pkg::angle_t ea;
  cwp_pkg::angle_t cur;
  cwp_pkg::angle_t cand;
  logic signed [cwp_pkg::SWEEP_W-1:0] prod;
  logic signed [cwp_pkg::IN_ANG_W:0]  diff;
  logic        fwd;
  logic        bwd;
  logic [cwp_pkg::CNT_W-1:0] cnt;
  logic        cont;
  logic        accept;

  assign diff = (cwp_pkg::IN_ANG_W+1)'($signed(s_tdata[2*cwp_pkg::IN_ANG_W-1:cwp_pkg::IN_ANG_W]))
              - (cwp_pkg::IN_ANG_W+1)'($signed(s_tdata[cwp_pkg::IN_ANG_W-1:0]));
  assign accept = s_tvalid && s_tready;

  assign cand = fwd ? cwp_pkg::next_corner(cur) : cwp_pkg::prev_corner(cur);
  assign cont = ((fwd && (cand < ea)) || (bwd && (cand > ea)))
             && (cnt < cwp_pkg::CNT_W'(cwp_pkg::MAX_CORNERS));

  always_comb begin
    state_next = state;
    case (state)
      cwp_pkg::FR_IDLE:   if (s_tvalid) state_next = cwp_pkg::FR_SWEEP;
      cwp_pkg::FR_SWEEP:  if (!full) state_next = cwp_pkg::FR_BEGIN;
      cwp_pkg::FR_BEGIN:  if (!full) state_next = cwp_pkg::FR_CORNER;
      cwp_pkg::FR_CORNER: if (!full && !cont) state_next = cwp_pkg::FR_IDLE;
      default:            state_next = cwp_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    push      = 1'b0;
    push_data = '0;
    case (state)
      cwp_pkg::FR_IDLE: begin
        s_tready = 1'b1;
      end
      cwp_pkg::FR_SWEEP: begin
        push             = !full;
        push_data.center = 1'b1;
      end
      cwp_pkg::FR_BEGIN: begin
        push            = !full;
        push_data.angle = b;
      end
      cwp_pkg::FR_CORNER: begin
        push            = !full;
        push_data.angle = cont ? cand : ea;
        push_data.last  = !cont;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwp_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b    <= cwp_pkg::ANG_W'($signed(s_tdata[cwp_pkg::IN_ANG_W-1:0]));
      prod <= cwp_pkg::SWEEP_W'(diff)
            * $signed({1'b0, s_tdata[2*cwp_pkg::IN_ANG_W+cwp_pkg::FILL_W-1:2*cwp_pkg::IN_ANG_W]});
    end
    if (state == cwp_pkg::FR_SWEEP) begin
      ea <= b + cwp_pkg::ANG_W'(prod >>> cwp_pkg::FRAC_BITS);
    end
    if (state == cwp_pkg::FR_BEGIN && !full) begin
      fwd <= b < ea;
      bwd <= b > ea;
      cur <= b;
      cnt <= '0;
    end
    if (state == cwp_pkg::FR_CORNER && !full && cont) begin
      cur <= cand;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

FILE: rtl/cwp_queue.sv
// Short command queue between the corner walker and the vertex pipeline.
`timescale 1ns / 1ps
module cwp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cwp_pkg::vtx_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output cwp_pkg::vtx_cmd_t pop_data,
  output logic              empty
);

  cwp_pkg::vtx_cmd_t entries [cwp_pkg::Q_DEPTH];
  logic [cwp_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [cwp_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [cwp_pkg::Q_PTR_W:0]   count;

  assign full     = count == (cwp_pkg::Q_PTR_W+1)'(cwp_pkg::Q_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

FILE: rtl/cwp_back.sv
// Back end: maps angles to square points and interpolates into screen and texture space.
`timescale 1ns / 1ps
module cwp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  cwp_pkg::cwp_cfg_t             cfg,
  input  logic                          empty,
  input  cwp_pkg::vtx_cmd_t             pop_data,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cwp_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tlast
);

  logic adv;
  cwp_pkg::rel_pt_t pt;

  logic                         v1;
  logic                         last1;
  logic [cwp_pkg::REL_W-1:0]    x1;
  logic [cwp_pkg::REL_W-1:0]    y1;

  logic                         v2;
  logic                         last2;
  logic [cwp_pkg::REL_W-1:0]    x2;
  logic [cwp_pkg::REL_W-1:0]    y2;
  logic signed [cwp_pkg::PS_W-1:0] px;
  logic signed [cwp_pkg::PS_W-1:0] py;
  logic signed [cwp_pkg::PT_W-1:0] pu;
  logic signed [cwp_pkg::PT_W-1:0] pv;

  logic signed [cwp_pkg::SCR_W:0] dx;
  logic signed [cwp_pkg::SCR_W:0] dy;
  logic signed [cwp_pkg::TEX_W:0] du;
  logic signed [cwp_pkg::TEX_W:0] dv;

  logic [cwp_pkg::SCR_W-1:0] scr_x;
  logic [cwp_pkg::SCR_W-1:0] scr_y;
  logic [cwp_pkg::TEX_W-1:0] tu;
  logic [cwp_pkg::TEX_W-1:0] tv;

  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !empty;
  assign pt  = cwp_pkg::perimeter(pop_data.angle);

  assign dx = (cwp_pkg::SCR_W+1)'(cfg.rect_right)  - (cwp_pkg::SCR_W+1)'(cfg.rect_left);
  assign dy = (cwp_pkg::SCR_W+1)'(cfg.rect_bottom) - (cwp_pkg::SCR_W+1)'(cfg.rect_top);
  assign du = $signed({1'b0, cfg.tex_right})  - $signed({1'b0, cfg.tex_left});
  assign dv = $signed({1'b0, cfg.tex_bottom}) - $signed({1'b0, cfg.tex_top});

  assign scr_x = cfg.rect_left + cwp_pkg::SCR_W'(px >>> cwp_pkg::FRAC_BITS);
  assign scr_y = cfg.rect_top  + cwp_pkg::SCR_W'(py >>> cwp_pkg::FRAC_BITS);
  assign tu    = cfg.tex_left  + cwp_pkg::TEX_W'(pu >>> cwp_pkg::FRAC_BITS);
  assign tv    = cfg.tex_top   + cwp_pkg::TEX_W'(pv >>> cwp_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= pop;
      v2       <= v1;
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last1 <= pop_data.last;
      if (pop_data.center) begin
        x1 <= cwp_pkg::REL_W'(cwp_pkg::HALF);
        y1 <= cwp_pkg::REL_W'(cwp_pkg::HALF);
      end else begin
        x1 <= pt.x;
        y1 <= pt.y;
      end

      last2 <= last1;
      x2    <= x1;
      y2    <= y1;
      px    <= cwp_pkg::PS_W'(dx) * $signed({1'b0, x1});
      py    <= cwp_pkg::PS_W'(dy) * $signed({1'b0, y1});
      pu    <= cwp_pkg::PT_W'(du) * $signed({1'b0, x1});
      pv    <= cwp_pkg::PT_W'(dv) * $signed({1'b0, y1});

      m_tlast <= last2;
      m_tdata <= {4'b0, tv, tu, scr_y, scr_x, y2, x2};
    end
  end

endmodule
